FILE: rtl/core/gbn_pkg.sv
// shared types and constants for the go-back-n sender window
package gbn_pkg;

  localparam int unsigned CNT_W  = 16;
  localparam int unsigned TMO_W  = 8;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CFG_W  = 16;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_TOTAL_PACKETS = 1'b0,
    CFG_TIMEOUT_POLLS = 1'b1
  } cfg_idx_t;

  // poll opcodes
  typedef enum logic [0:0] {
    OP_POLL     = 1'b0,
    OP_POLL_ACK = 1'b1
  } op_t;

  // classified poll, front to back
  typedef struct packed {
    logic              is_ack;
    logic              ack_hit;
    logic [BYTE_W-1:0] ack_idx;
  } cmd_t;

  // queue status toward the front and back
  typedef struct packed {
    logic full;
    logic nonempty;
  } q_stat_t;

  // one result
  typedef struct packed {
    logic              send_valid;
    logic [BYTE_W-1:0] send_seq;
    logic [CNT_W-1:0]  send_packet_index;
    logic              ack_accepted;
    logic              timeout_fired;
    logic [CNT_W-1:0]  acked_total;
    logic              done_res;
  } res_t;

endpackage

FILE: rtl/core/gbn_front.sv
// front end: takes polls and classifies the ack byte
module gbn_front
  import gbn_pkg::*;
#(
  parameter int unsigned SEQ_COUNT = 20
) (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [0:0]        in_opcode,
  input  logic [BYTE_W-1:0] in_ack_byte,
  input  q_stat_t           q_stat,
  output logic              push,
  output cmd_t              push_cmd
);

  localparam logic [BYTE_W-1:0] SEQ_L = BYTE_W'(SEQ_COUNT);

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  always_comb begin
    push_cmd.is_ack  = (op_t'(in_opcode) == OP_POLL_ACK);
    // ack of zero or past the sequence space is dropped
    push_cmd.ack_hit = push_cmd.is_ack && (in_ack_byte != '0) && (in_ack_byte <= SEQ_L);
    push_cmd.ack_idx = in_ack_byte - BYTE_W'(1);
  end

endmodule

FILE: rtl/core/gbn_queue.sv
// two-entry queue between front and back
module gbn_queue
  import gbn_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    pop_cmd,
  output q_stat_t q_stat
);

  cmd_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign pop_cmd         = mem_r[rd_ptr_r];
  assign q_stat.full     = count_r[1];
  assign q_stat.nonempty = (count_r != 2'd0);

endmodule

FILE: rtl/core/gbn_back.sv
// back end: window state, send decision, ack and timeout handling
module gbn_back
  import gbn_pkg::*;
#(
  parameter int unsigned SEQ_COUNT = 20,
  parameter int unsigned WINDOW    = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] total_packets,
  input  logic [TMO_W-1:0] timeout_polls,
  input  q_stat_t          q_stat,
  input  cmd_t             pop_cmd,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output res_t             out_res
);

  localparam int unsigned SEQ_W   = $clog2(SEQ_COUNT);
  localparam int unsigned DW      = SEQ_W + 1;
  localparam int unsigned CW      = $clog2(SEQ_COUNT + 1);
  localparam int unsigned WIN_EFF = (WINDOW < SEQ_COUNT) ? WINDOW : SEQ_COUNT;
  localparam logic [DW-1:0]    WIN_L  = DW'(WIN_EFF);
  localparam logic [DW-1:0]    SEQ_DL = DW'(SEQ_COUNT);
  localparam logic [SEQ_W-1:0] LAST_L = SEQ_W'(SEQ_COUNT - 1);

  logic [SEQ_COUNT-1:0] slot_free_r, slot_free_nxt;
  logic [SEQ_W-1:0]     next_seq_r, next_seq_nxt;
  logic [SEQ_W-1:0]     base_r, base_nxt;
  logic [CNT_W-1:0]     sent_r, sent_nxt;
  logic [CNT_W-1:0]     acked_r, acked_nxt;
  logic [TMO_W-1:0]     idle_r, idle_nxt;
  logic                 finished_r, finished_nxt;
  logic                 out_valid_r;
  res_t                 res_r, res_nxt;

  function automatic logic [DW-1:0] seq_dist(input logic [SEQ_W-1:0] from_s,
                                             input logic [SEQ_W-1:0] to_s);
    logic [DW-1:0] f;
    logic [DW-1:0] t;
    f = DW'(from_s);
    t = DW'(to_s);
    seq_dist = (t >= f) ? (t - f) : (t + SEQ_DL - f);
  endfunction

  logic                 send;
  logic [SEQ_COUNT-1:0] free1;
  logic [SEQ_W-1:0]     next1;
  logic [CNT_W-1:0]     sent1;
  logic [TMO_W:0]       idle1;
  logic [SEQ_COUNT-1:0] win_mask;
  logic [CW-1:0]        undone;
  logic [SEQ_W-1:0]     ack_a;
  logic [DW-1:0]        ack_d;
  logic [DW-1:0]        outstanding;
  logic [CNT_W:0]       acked_sum;

  assign pop = q_stat.nonempty && (!out_valid_r || !out_stall);

  always_comb begin
    slot_free_nxt = slot_free_r;
    next_seq_nxt  = next_seq_r;
    base_nxt      = base_r;
    sent_nxt      = sent_r;
    acked_nxt     = acked_r;
    idle_nxt      = idle_r;
    finished_nxt  = finished_r;
    res_nxt       = '0;
    send          = 1'b0;
    free1         = slot_free_r;
    next1         = next_seq_r;
    sent1         = sent_r;
    idle1         = {1'b0, idle_r} + (TMO_W + 1)'(1);
    undone        = '0;
    ack_a         = pop_cmd.ack_idx[SEQ_W-1:0];
    ack_d         = seq_dist(base_r, ack_a);
    outstanding   = '0;
    acked_sum     = '0;

    // slots that lie inside the window from the current base
    for (int i = 0; i < SEQ_COUNT; i++) begin
      win_mask[i] = (seq_dist(base_r, SEQ_W'(i)) < WIN_L);
    end

    if (!finished_r) begin
      // send stage
      send = slot_free_r[next_seq_r] && (seq_dist(base_r, next_seq_r) < WIN_L) &&
             (sent_r < total_packets);
      if (send) begin
        free1[next_seq_r] = 1'b0;
        next1             = (next_seq_r == LAST_L) ? '0 : next_seq_r + SEQ_W'(1);
        sent1             = sent_r + CNT_W'(1);
      end
      res_nxt.send_valid        = send;
      res_nxt.send_seq          = send ? BYTE_W'(next_seq_r) + BYTE_W'(1) : '0;
      res_nxt.send_packet_index = send ? sent_r : '0;

      slot_free_nxt = free1;
      next_seq_nxt  = next1;
      sent_nxt      = sent1;

      if (!pop_cmd.is_ack) begin
        if (idle1 > {1'b0, timeout_polls}) begin
          // go back: free the window and rewind to the base
          for (int i = 0; i < SEQ_COUNT; i++) begin
            undone = undone + CW'(win_mask[i] && !free1[i]);
          end
          slot_free_nxt = free1 | win_mask;
          sent_nxt      = (CNT_W'(undone) > sent1) ? '0 : sent1 - CNT_W'(undone);
          next_seq_nxt  = base_r;
          idle_nxt      = '0;
          res_nxt.timeout_fired = 1'b1;
        end else begin
          idle_nxt = idle1[TMO_W-1:0];
        end
      end else begin
        idle_nxt    = '0;
        outstanding = seq_dist(base_r, next1);
        if (pop_cmd.ack_hit && (ack_d < outstanding)) begin
          // cumulative ack frees base through the acked slot
          for (int i = 0; i < SEQ_COUNT; i++) begin
            if (seq_dist(base_r, SEQ_W'(i)) <= ack_d) begin
              slot_free_nxt[i] = 1'b1;
            end
          end
          base_nxt  = (ack_a == LAST_L) ? '0 : ack_a + SEQ_W'(1);
          acked_sum = {1'b0, acked_r} + (CNT_W + 1)'(ack_d) + (CNT_W + 1)'(1);
          acked_nxt = acked_sum[CNT_W] ? '1 : acked_sum[CNT_W-1:0];
          res_nxt.ack_accepted = 1'b1;
        end
      end

      if (acked_nxt == total_packets) begin
        finished_nxt = 1'b1;
      end
    end

    res_nxt.acked_total = acked_nxt;
    res_nxt.done_res    = finished_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_free_r <= '1;
      next_seq_r  <= '0;
      base_r      <= '0;
      sent_r      <= '0;
      acked_r     <= '0;
      idle_r      <= '0;
      finished_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        slot_free_r <= slot_free_nxt;
        next_seq_r  <= next_seq_nxt;
        base_r      <= base_nxt;
        sent_r      <= sent_nxt;
        acked_r     <= acked_nxt;
        idle_r      <= idle_nxt;
        finished_r  <= finished_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

FILE: rtl/core/go_back_n_sender_window.sv
// top level of the go-back-n sender window
//
//  channel | ports                                  | handshake
//  --------+----------------------------------------+-----------------------------
//  in      | in_opcode, in_ack_byte                 | in_valid / in_stall
//  out     | out_send_valid .. out_done_res         | out_valid / out_stall
//  cfg     | cfg_we, cfg_index, cfg_data            | write on cfg_we, no wait
//
//  one poll per cycle unless in_stall or out_stall holds the flow; the back end applies a whole
//  poll in one combinational step, and a taken poll goes to a queue entry, then the result register
//  a two-entry queue sits between classification and the window state
//  rst_n is synchronous; window state returns to all slots free, counters zero
//  a stalled result holds in the output register while the queue keeps filling
module go_back_n_sender_window
  import gbn_pkg::*;
#(
  parameter int unsigned SEQ_COUNT = 20,
  parameter int unsigned WINDOW    = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  // poll input
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [0:0]        in_opcode,
  input  logic [BYTE_W-1:0] in_ack_byte,
  // result output
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_send_valid,
  output logic [BYTE_W-1:0] out_send_seq,
  output logic [CNT_W-1:0]  out_send_packet_index,
  output logic              out_ack_accepted,
  output logic              out_timeout_fired,
  output logic [CNT_W-1:0]  out_acked_total,
  output logic              out_done_res,
  // configuration writes
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  // configuration registers with their reset values
  logic [CNT_W-1:0] total_packets_r;
  logic [TMO_W-1:0] timeout_polls_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_packets_r <= CNT_W'(25);
      timeout_polls_r <= TMO_W'(20);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TOTAL_PACKETS: total_packets_r <= cfg_data;
        CFG_TIMEOUT_POLLS: timeout_polls_r <= cfg_data[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  // front to queue
  logic    push;
  cmd_t    push_cmd;
  q_stat_t q_stat;
  // queue to back
  logic    pop;
  cmd_t    pop_cmd;
  res_t    res;

  // classify each poll transaction
  gbn_front #(
    .SEQ_COUNT(SEQ_COUNT)
  ) u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_opcode  (in_opcode),
    .in_ack_byte(in_ack_byte),
    .q_stat     (q_stat),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  // decouple intake from window update
  gbn_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .pop_cmd (pop_cmd),
    .q_stat  (q_stat)
  );

  // window state, sending, acks and timeout rewind
  gbn_back #(
    .SEQ_COUNT(SEQ_COUNT),
    .WINDOW   (WINDOW)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .total_packets(total_packets_r),
    .timeout_polls(timeout_polls_r),
    .q_stat       (q_stat),
    .pop_cmd      (pop_cmd),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_res      (res)
  );

  // unpack the registered result
  assign out_send_valid        = res.send_valid;
  assign out_send_seq          = res.send_seq;
  assign out_send_packet_index = res.send_packet_index;
  assign out_ack_accepted      = res.ack_accepted;
  assign out_timeout_fired     = res.timeout_fired;
  assign out_acked_total       = res.acked_total;
  assign out_done_res          = res.done_res;

endmodule

FILE: verif/gbn_window_check.sv
// result prediction and comparison for the go-back-n sender window
module gbn_window_check
  import gbn_pkg::*;
#(
  parameter int unsigned SEQ_COUNT = 20,
  parameter int unsigned WINDOW    = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [0:0]        in_opcode,
  input  logic [BYTE_W-1:0] in_ack_byte,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              out_send_valid,
  input  logic [BYTE_W-1:0] out_send_seq,
  input  logic [CNT_W-1:0]  out_send_packet_index,
  input  logic              out_ack_accepted,
  input  logic              out_timeout_fired,
  input  logic [CNT_W-1:0]  out_acked_total,
  input  logic              out_done_res,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  output int                mismatches,
  output int                results_owed,
  output int                model_base,
  output int                model_next,
  output logic [CNT_W-1:0]  model_acked,
  output logic              model_done
);
  timeunit 1ns;
  timeprecision 1ps;

  // window state as the block should hold it
  logic [SEQ_COUNT-1:0] slot_open;
  int unsigned          seq_next;
  int unsigned          seq_base;
  int unsigned          idle_run;
  logic [CNT_W-1:0]     sent_total;
  logic [CNT_W-1:0]     acked_sum;
  logic                 xfer_finished;
  logic [CNT_W-1:0]     pkt_limit;
  logic [TMO_W-1:0]     idle_limit;

  res_t owed_q[$];
  int   fail_total = 0;
  int   result_no  = 0;

  function automatic int unsigned ring_gap(int unsigned from, int unsigned to);
    return (to + SEQ_COUNT - from) % SEQ_COUNT;
  endfunction

  // one poll: send if allowed, then the ack or the idle count
  function automatic res_t take_poll(op_t op, logic [BYTE_W-1:0] ack);
    res_t        r;
    int unsigned i;
    int unsigned reach;
    int unsigned in_flight;
    int unsigned rewound;
    int unsigned sum;
    r = '0;
    if (!xfer_finished) begin
      if (slot_open[seq_next] && ring_gap(seq_base, seq_next) < WINDOW &&
          sent_total < pkt_limit) begin
        r.send_valid        = 1'b1;
        r.send_seq          = BYTE_W'(seq_next + 1);
        r.send_packet_index = sent_total;
        slot_open[seq_next] = 1'b0;
        seq_next            = (seq_next + 1) % SEQ_COUNT;
        sent_total          = sent_total + 1'b1;
      end
      if (op == OP_POLL) begin
        idle_run++;
        if (idle_run > idle_limit) begin
          // go back: free the window, drop unacked sends, resend from the base
          rewound = 0;
          for (i = 0; i < WINDOW; i++) begin
            if (!slot_open[(seq_base + i) % SEQ_COUNT]) rewound++;
            slot_open[(seq_base + i) % SEQ_COUNT] = 1'b1;
          end
          sent_total      = (rewound > sent_total) ? '0 : sent_total - CNT_W'(rewound);
          seq_next        = seq_base;
          idle_run        = 0;
          r.timeout_fired = 1'b1;
        end
      end else begin
        idle_run = 0;
        if (ack >= 1 && ack <= SEQ_COUNT) begin
          reach     = ring_gap(seq_base, ack - 1);
          in_flight = ring_gap(seq_base, seq_next);
          // cumulative ack, only for packets still outstanding
          if (reach < in_flight) begin
            for (i = 0; i <= reach; i++) slot_open[(seq_base + i) % SEQ_COUNT] = 1'b1;
            seq_base       = ack % SEQ_COUNT;
            sum            = acked_sum + reach + 1;
            acked_sum      = (sum > 32'hFFFF) ? '1 : CNT_W'(sum);
            r.ack_accepted = 1'b1;
          end
        end
      end
      if (acked_sum == pkt_limit) xfer_finished = 1'b1;
    end
    r.acked_total = acked_sum;
    r.done_res    = xfer_finished;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got_v,
                               input logic [31:0] want_v);
    if (fail_total < 100)
      $display("[%0t] result %0d: %s is %0h, want %0h", $time, result_no, what, got_v, want_v);
    fail_total++;
  endtask

  always @(posedge clk) begin : track
    res_t seen;
    res_t want;
    if (!rst_n) begin
      slot_open     = '1;
      seq_next      = 0;
      seq_base      = 0;
      idle_run      = 0;
      sent_total    = '0;
      acked_sum     = '0;
      xfer_finished = 1'b0;
      pkt_limit     = 16'd25;
      idle_limit    = 8'd20;
      owed_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_TOTAL_PACKETS: pkt_limit = cfg_data;
          CFG_TIMEOUT_POLLS: idle_limit = cfg_data[TMO_W-1:0];
          default: ;
        endcase
      end
      // results before polls, a poll taken on this edge has no result yet
      if (out_valid && !out_stall) begin
        seen = {out_send_valid, out_send_seq, out_send_packet_index, out_ack_accepted,
                out_timeout_fired, out_acked_total, out_done_res};
        result_no++;
        if (owed_q.size() == 0) begin
          flag_mismatch("result with none owed", 1, 0);
        end else begin
          want = owed_q.pop_front();
          if (seen.send_valid !== want.send_valid)
            flag_mismatch("send_valid", seen.send_valid, want.send_valid);
          if (seen.send_seq !== want.send_seq)
            flag_mismatch("send_seq", seen.send_seq, want.send_seq);
          if (seen.send_packet_index !== want.send_packet_index)
            flag_mismatch("send_packet_index", seen.send_packet_index, want.send_packet_index);
          if (seen.ack_accepted !== want.ack_accepted)
            flag_mismatch("ack_accepted", seen.ack_accepted, want.ack_accepted);
          if (seen.timeout_fired !== want.timeout_fired)
            flag_mismatch("timeout_fired", seen.timeout_fired, want.timeout_fired);
          if (seen.acked_total !== want.acked_total)
            flag_mismatch("acked_total", seen.acked_total, want.acked_total);
          if (seen.done_res !== want.done_res)
            flag_mismatch("done_res", seen.done_res, want.done_res);
        end
      end
      if (in_valid && !in_stall) owed_q.push_back(take_poll(op_t'(in_opcode), in_ack_byte));
    end
    mismatches   <= fail_total;
    results_owed <= owed_q.size();
    model_base   <= seq_base;
    model_next   <= seq_next;
    model_acked  <= acked_sum;
    model_done   <= xfer_finished;
  end

endmodule

FILE: verif/go_back_n_sender_window_tb.sv
// top-level testbench for the go-back-n sender window
module go_back_n_sender_window_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gbn_pkg::*;

  localparam int unsigned SEQ_COUNT   = 20;
  localparam int unsigned WINDOW      = 10;
  // length of the long receiver hold-off, long enough to back up the queue
  localparam int unsigned HOLD_CYCLES = 48;

  logic              clk;
  logic              rst_n                 = 1'b0;
  logic              in_valid              = 1'b0;
  logic              in_stall;
  logic [0:0]        in_opcode             = OP_POLL;
  logic [BYTE_W-1:0] in_ack_byte           = '0;
  logic              out_valid;
  logic              out_stall             = 1'b0;
  logic              out_send_valid;
  logic [BYTE_W-1:0] out_send_seq;
  logic [CNT_W-1:0]  out_send_packet_index;
  logic              out_ack_accepted;
  logic              out_timeout_fired;
  logic [CNT_W-1:0]  out_acked_total;
  logic              out_done_res;
  logic              cfg_we                = 1'b0;
  logic [0:0]        cfg_index             = CFG_TOTAL_PACKETS;
  logic [CFG_W-1:0]  cfg_data              = '0;

  // view of the predicted state, used to aim acks and to end the transfer
  int                mismatches;
  int                results_owed;
  int                model_base;
  int                model_next;
  logic [CNT_W-1:0]  model_acked;
  logic              model_done;

  // traffic shaping shared by the sender and receiver processes
  int unsigned       snd_idle_pct  = 25;
  int unsigned       rcv_stall_pct = 63;
  int                hold_req      = 0;
  logic [TMO_W-1:0]  tmo_now       = 8'd20;

  go_back_n_sender_window #(
    .SEQ_COUNT(SEQ_COUNT),
    .WINDOW   (WINDOW)
  ) dut (.*);

  gbn_window_check #(
    .SEQ_COUNT(SEQ_COUNT),
    .WINDOW   (WINDOW)
  ) window_check (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // offer one poll transaction, with optional idle cycles in front of it
  // returns on the edge where the block takes it
  task automatic offer_poll(input op_t op, input logic [BYTE_W-1:0] ack);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_ack_byte <= ack;
    do @(posedge clk); while (in_stall);
  endtask

  // stop offering and wait until every owed result has come out
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  // both registers back to back, only while the block is idle
  task automatic program_window(input logic [CNT_W-1:0] total, input logic [TMO_W-1:0] tmo);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TOTAL_PACKETS;
    cfg_data  <= total;
    @(posedge clk);
    cfg_index <= CFG_TIMEOUT_POLLS;
    cfg_data  <= CFG_W'(tmo);
    @(posedge clk);
    cfg_we    <= 1'b0;
    tmo_now   = tmo;
  endtask

  // random traffic, mostly acks aimed at outstanding packets
  task automatic poll_mix(input int unsigned count, input bit stop_at_done);
    int unsigned k;
    int unsigned j;
    int unsigned pick;
    int unsigned in_flight;
    for (k = 0; k < count; k++) begin
      if (stop_at_done && model_done) break;
      pick      = $urandom_range(99);
      in_flight = (model_next + SEQ_COUNT - model_base) % SEQ_COUNT;
      if (pick == 0) begin
        // idle run just long enough to trip the timeout
        for (j = 0; j <= tmo_now; j++) offer_poll(OP_POLL, BYTE_W'($urandom));
      end else if (pick < 55 && in_flight != 0) begin
        // cumulative ack somewhere inside the outstanding span
        offer_poll(OP_POLL_ACK,
                   BYTE_W'((model_base + $urandom_range(in_flight - 1)) % SEQ_COUNT + 1));
      end else if (pick < 80) begin
        offer_poll(OP_POLL, BYTE_W'($urandom));
      end else if (pick < 90) begin
        offer_poll(OP_POLL_ACK, BYTE_W'($urandom));
      end else begin
        offer_poll(OP_POLL_ACK, BYTE_W'($urandom_range(SEQ_COUNT, 1)));
      end
    end
  endtask

  // result side: random stalls, plus a long hold-off on request
  initial begin : result_sink
    int unsigned held;
    int          holds_done;
    held       = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold_req > holds_done) begin
        out_stall <= 1'b1;
        held++;
        if (held == HOLD_CYCLES) begin
          held = 0;
          holds_done++;
        end
      end else begin
        out_stall <= ($urandom_range(99) < rcv_stall_pct);
      end
    end
  end

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part on the reset settings: 25 packets, timeout after 20 idle polls
    offer_poll(OP_POLL, 8'h00);       // first send, seq 1
    offer_poll(OP_POLL, 8'hFF);       // ack byte ignored without the ack opcode
    offer_poll(OP_POLL_ACK, 8'h00);   // ack byte zero ignored
    offer_poll(OP_POLL_ACK, 8'hFF);   // ack byte far out of range
    offer_poll(OP_POLL_ACK, 8'd21);   // just above the sequence space
    offer_poll(OP_POLL_ACK, 8'd20);   // in range but never sent
    offer_poll(OP_POLL_ACK, 8'd2);    // cumulative ack of two packets
    offer_poll(OP_POLL_ACK, 8'd1);    // stale ack, base must not move back
    repeat (4) offer_poll(OP_POLL, 8'h5A);
    offer_poll(OP_POLL, 8'hA5);       // window full, nothing goes out
    offer_poll(OP_POLL_ACK, 8'd12);   // acks the whole window at once
    offer_poll(OP_POLL, 8'h00);

    // largest transfer, timeout on the first idle poll
    settle();
    program_window(16'hFFFF, 8'd0);
    offer_poll(OP_POLL, 8'h00);       // send then go back to the base
    offer_poll(OP_POLL_ACK, 8'd13);   // resent packet acked
    hold_req <= hold_req + 1;
    poll_mix(220, 1'b0);

    // sender idles more than the receiver stalls from here
    settle();
    snd_idle_pct  = 63;
    rcv_stall_pct = 25;
    // no packets left to send, acks drain what is still out
    program_window(16'd0, 8'd3);
    poll_mix(60, 1'b0);
    settle();
    program_window(CNT_W'($urandom_range(65534, 2000)), 8'hFF);
    poll_mix(220, 1'b0);

    // no idling from here, one more long hold-off
    settle();
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    program_window(CNT_W'($urandom_range(65534, 2000)), TMO_W'($urandom_range(12, 1)));
    hold_req <= hold_req + 1;
    poll_mix(220, 1'b0);

    // finish the transfer a few packets past what is acked now
    settle();
    program_window(model_acked + 16'd12, TMO_W'($urandom_range(6, 2)));
    poll_mix(3000, 1'b1);
    poll_mix(10, 1'b0);
    // register writes must not clear the finished state
    settle();
    program_window(16'd0, TMO_W'($urandom));
    repeat (5) offer_poll(OP_POLL, BYTE_W'($urandom));

    settle();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && results_owed == 0) begin
      $display("go_back_n_sender_window verification clean");
    end else begin
      $display("go_back_n_sender_window verification failed");
    end
    $finish;
  end

  // hang guard
  initial begin
    #5ms;
    $display("go_back_n_sender_window verification failed");
    $finish;
  end

endmodule
